### design/rgbd_pixel_to_point_defines.svh
// Assertion macros for the pixel-to-point block.
// Included by the top level; no other dependencies.
`ifndef RGBD_PIXEL_TO_POINT_DEFINES_SVH
`define RGBD_PIXEL_TO_POINT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RGBD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`define RGBD_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`else
`define RGBD_NEVER(lbl, cond, msg)
`define RGBD_HOLDS(lbl, prop, msg)
`endif
`endif

### design/rgbd_pkg.sv
// Shared types and constants for the pixel-to-point block.
// No dependencies.
package rgbd_pkg;

	localparam int FRAME_WIDTH_DEF = 1920;

	localparam int PIX_W      = 12;
	localparam int EDGE_W     = PIX_W + 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;
	localparam int BACK_LAT  = 6;
	localparam int INFL_W    = $clog2(BACK_LAT + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRINCIPAL_X     = 3'd0,
		REG_PRINCIPAL_Y     = 3'd1,
		REG_INV_FOCAL_X     = 3'd2,
		REG_INV_FOCAL_Y     = 3'd3,
		REG_INV_DEPTH_SCALE = 3'd4,
		REG_COLUMN_TRIM     = 3'd5,
		REG_ALPHA_THRESHOLD = 3'd6
	} cfg_reg_t;

	localparam logic [15:0] RST_PRINCIPAL_X     = 16'd15573;
	localparam logic [15:0] RST_PRINCIPAL_Y     = 16'd8264;
	localparam logic [24:0] RST_INV_FOCAL_X     = 25'd15983;
	localparam logic [24:0] RST_INV_FOCAL_Y     = 25'd16016;
	localparam logic [16:0] RST_INV_DEPTH_SCALE = 17'd6554;
	localparam logic [10:0] RST_COLUMN_TRIM     = 11'd300;
	localparam logic [7:0]  RST_ALPHA_THRESHOLD = 8'd10;

	typedef struct packed {
		logic [15:0] principal_x;
		logic [15:0] principal_y;
		logic [24:0] inv_focal_x;
		logic [24:0] inv_focal_y;
		logic [16:0] inv_depth_scale;
		logic [10:0] column_trim;
		logic [7:0]  alpha_threshold;
	} cfg_t;

	typedef struct packed {
		logic [15:0]      depth_raw;
		logic [7:0]       color_first;
		logic [7:0]       color_second;
		logic [7:0]       color_third;
		logic [7:0]       alpha_level;
		logic [PIX_W-1:0] pixel_column;
		logic [PIX_W-1:0] pixel_row;
	} pixel_t;

	typedef struct packed {
		logic [23:0]        point_forward;
		logic signed [31:0] point_right;
		logic signed [31:0] point_up;
		logic [7:0]         out_first;
		logic [7:0]         out_second;
		logic [7:0]         out_third;
	} point_t;

	typedef struct packed {
		logic   valid;
		pixel_t word;
	} kept_t;

endpackage

### design/rgbd_fifo.sv
// Small register queue used between the front, the back and the output.
// No dependencies.
module rgbd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       rd,
	output logic [WIDTH-1:0]           rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= nxt(wptr_q);
			end
			if (rd) begin
				rptr_q <= nxt(rptr_q);
			end
			count_q <= count_q + CW'(wr) - CW'(rd);
		end
	end

	assign rdata = mem_q[rptr_q];
	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;
endmodule

### design/rgbd_front.sv
// Front end: takes pixels and masks out the ones that give no point.
// Depends on rgbd_pkg.
module rgbd_front #(
	parameter int FRAME_WIDTH = rgbd_pkg::FRAME_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rgbd_pkg::cfg_t  cfg,
	input  logic            push,
	input  rgbd_pkg::pixel_t pixel,
	output logic            full,
	input  logic            ready,
	output rgbd_pkg::kept_t kept
);
	localparam int EW = rgbd_pkg::EDGE_W;

	logic                 valid_s1;
	rgbd_pkg::pixel_t     word_s1;
	logic signed [EW-1:0] right_edge;
	logic                 keep;
	logic                 accept;

	assign right_edge = EW'(FRAME_WIDTH) - $signed(EW'(cfg.column_trim));

	assign keep = (pixel.depth_raw != '0)
		&& (pixel.alpha_level >= cfg.alpha_threshold)
		&& !pixel.pixel_row[0]
		&& ({1'b0, pixel.pixel_column} >= {2'b0, cfg.column_trim})
		&& ($signed(EW'(pixel.pixel_column)) < right_edge)
		&& (pixel.pixel_column[0] == cfg.column_trim[0]);

	assign full   = valid_s1 && !ready;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= pixel;
		end
	end

	assign kept.valid = valid_s1;
	assign kept.word  = word_s1;
endmodule

### design/rgbd_back.sv
// Back end: six-stage back-projection pipeline, one kept pixel per clock.
// Depends on rgbd_pkg.
module rgbd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rgbd_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	input  rgbd_pkg::pixel_t            in_word,
	output logic                        out_valid,
	output rgbd_pkg::point_t            out_word,
	output logic [rgbd_pkg::INFL_W-1:0] inflight
);
	localparam int LAT = rgbd_pkg::BACK_LAT;

	logic [LAT-1:0] valid_q;

	logic [32:0] zprod_s1;
	logic [16:0] offx_s1, offy_s1;
	logic [23:0] colour_s1, colour_s2, colour_s3, colour_s4, colour_s5;

	logic [23:0] z_s2, z_s3, z_s4, z_s5;
	logic [15:0] magx_s2, magy_s2;
	logic        sx_s2, sy_s2, sx_s3, sy_s3, sx_s4, sy_s4, sx_s5, sy_s5;

	logic [39:0] mx_s3, my_s3;
	logic [44:0] ax_s4, bx_s4, ay_s4, by_s4;
	logic [37:0] qx_s5, qy_s5;
	logic        rx_s5, ry_s5;
	logic [65:0] sumx, sumy;

	logic signed [39:0] qx_ext, qy_ext, qrx, qry, vx, vy;
	rgbd_pkg::point_t   point_s6;

	function automatic logic [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end else if (v < -40'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		zprod_s1  <= 33'(in_word.depth_raw) * 33'(cfg.inv_depth_scale);
		offx_s1   <= {1'b0, in_word.pixel_column, 4'b0} - {1'b0, cfg.principal_x};
		offy_s1   <= {1'b0, in_word.pixel_row, 4'b0} - {1'b0, cfg.principal_y};
		colour_s1 <= {in_word.color_first, in_word.color_second, in_word.color_third};
	end

	always_ff @(posedge clk) begin
		z_s2      <= zprod_s1[32] ? '1 : zprod_s1[31:8];
		sx_s2     <= offx_s1[16];
		sy_s2     <= offy_s1[16];
		magx_s2   <= offx_s1[16] ? 16'(-offx_s1) : offx_s1[15:0];
		magy_s2   <= offy_s1[16] ? 16'(-offy_s1) : offy_s1[15:0];
		colour_s2 <= colour_s1;
	end

	always_ff @(posedge clk) begin
		mx_s3     <= 40'(magx_s2) * 40'(z_s2);
		my_s3     <= 40'(magy_s2) * 40'(z_s2);
		z_s3      <= z_s2;
		sx_s3     <= sx_s2;
		sy_s3     <= sy_s2;
		colour_s3 <= colour_s2;
	end

	always_ff @(posedge clk) begin
		ax_s4     <= 45'(mx_s3[39:20]) * 45'(cfg.inv_focal_x);
		bx_s4     <= 45'(mx_s3[19:0]) * 45'(cfg.inv_focal_x);
		ay_s4     <= 45'(my_s3[39:20]) * 45'(cfg.inv_focal_y);
		by_s4     <= 45'(my_s3[19:0]) * 45'(cfg.inv_focal_y);
		z_s4      <= z_s3;
		sx_s4     <= sx_s3;
		sy_s4     <= sy_s3;
		colour_s4 <= colour_s3;
	end

	assign sumx = {1'b0, ax_s4, 20'b0} + 66'(bx_s4);
	assign sumy = {1'b0, ay_s4, 20'b0} + 66'(by_s4);

	always_ff @(posedge clk) begin
		qx_s5     <= sumx[65:28];
		rx_s5     <= |sumx[27:0];
		qy_s5     <= sumy[65:28];
		ry_s5     <= |sumy[27:0];
		z_s5      <= z_s4;
		sx_s5     <= sx_s4;
		sy_s5     <= sy_s4;
		colour_s5 <= colour_s4;
	end

	// floor for negative offsets: -(q + any remainder); y is negated once more
	assign qx_ext = $signed({2'b0, qx_s5});
	assign qy_ext = $signed({2'b0, qy_s5});
	assign qrx    = qx_ext + 40'(rx_s5);
	assign qry    = qy_ext + 40'(ry_s5);
	assign vx     = sx_s5 ? -qrx : qx_ext;
	assign vy     = sy_s5 ? qry : -qy_ext;

	always_ff @(posedge clk) begin
		point_s6.point_forward <= z_s5;
		point_s6.point_right   <= sat32(vx);
		point_s6.point_up      <= sat32(vy);
		point_s6.out_first     <= colour_s5[23:16];
		point_s6.out_second    <= colour_s5[15:8];
		point_s6.out_third     <= colour_s5[7:0];
	end

	assign out_valid = valid_q[LAT-1];
	assign out_word  = point_s6;
	assign inflight  = rgbd_pkg::INFL_W'($countones(valid_q));
endmodule

### design/rgbd_pixel_to_point.sv
// Pixel-to-point top level: masks RGBA-D pixels and back-projects the kept
// ones through a pinhole model. Depends on rgbd_pkg, rgbd_front, rgbd_fifo,
// rgbd_back and rgbd_pixel_to_point_defines.svh.
//
// One pixel is taken every clock, kept or not, unless a kept pixel waits in
// the mask stage while the middle queue is full; a dropped pixel gives no
// word. A kept pixel goes through one mask stage, a four-word queue, the
// six-stage multiplier pipeline of the back end and an eight-word output
// queue to the result side. The back end only starts a pixel when the
// output queue has room for everything in flight, so stalls on the result
// side back up through the queues to full. No clearing pass after reset.
`include "rgbd_pixel_to_point_defines.svh"

module rgbd_pixel_to_point #(
	parameter int FRAME_WIDTH = rgbd_pkg::FRAME_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [rgbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgbd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            push,
	input  rgbd_pkg::pixel_t                pixel,
	output logic                            full,
	output logic                            empty,
	input  logic                            pop,
	output rgbd_pkg::point_t                point
);
	localparam int OUT_CW = $clog2(rgbd_pkg::OUT_DEPTH + 1);
	localparam int MID_CW = $clog2(rgbd_pkg::MID_DEPTH + 1);
	localparam int SUM_W  = OUT_CW + 1;

	rgbd_pkg::cfg_t   cfg_q;
	rgbd_pkg::kept_t  kept;
	rgbd_pkg::pixel_t mid_word;
	rgbd_pkg::point_t back_word;

	logic mid_wr, mid_rd, mid_full, mid_empty;
	logic back_valid, out_full, out_empty;
	logic [MID_CW-1:0]           mid_count;
	logic [OUT_CW-1:0]           out_count;
	logic [rgbd_pkg::INFL_W-1:0] inflight;
	logic                        credit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.principal_x     <= rgbd_pkg::RST_PRINCIPAL_X;
			cfg_q.principal_y     <= rgbd_pkg::RST_PRINCIPAL_Y;
			cfg_q.inv_focal_x     <= rgbd_pkg::RST_INV_FOCAL_X;
			cfg_q.inv_focal_y     <= rgbd_pkg::RST_INV_FOCAL_Y;
			cfg_q.inv_depth_scale <= rgbd_pkg::RST_INV_DEPTH_SCALE;
			cfg_q.column_trim     <= rgbd_pkg::RST_COLUMN_TRIM;
			cfg_q.alpha_threshold <= rgbd_pkg::RST_ALPHA_THRESHOLD;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rgbd_pkg::REG_PRINCIPAL_X:     cfg_q.principal_x     <= cfg_data[15:0];
				rgbd_pkg::REG_PRINCIPAL_Y:     cfg_q.principal_y     <= cfg_data[15:0];
				rgbd_pkg::REG_INV_FOCAL_X:     cfg_q.inv_focal_x     <= cfg_data[24:0];
				rgbd_pkg::REG_INV_FOCAL_Y:     cfg_q.inv_focal_y     <= cfg_data[24:0];
				rgbd_pkg::REG_INV_DEPTH_SCALE: cfg_q.inv_depth_scale <= cfg_data[16:0];
				rgbd_pkg::REG_COLUMN_TRIM:     cfg_q.column_trim     <= cfg_data[10:0];
				rgbd_pkg::REG_ALPHA_THRESHOLD: cfg_q.alpha_threshold <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	rgbd_front #(
		.FRAME_WIDTH(FRAME_WIDTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.push  (push),
		.pixel (pixel),
		.full  (full),
		.ready (!mid_full),
		.kept  (kept)
	);

	assign mid_wr = kept.valid && !mid_full;

	rgbd_fifo #(
		.WIDTH($bits(rgbd_pkg::pixel_t)),
		.DEPTH(rgbd_pkg::MID_DEPTH)
	) u_mid (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (mid_wr),
		.wdata (kept.word),
		.rd    (mid_rd),
		.rdata (mid_word),
		.full  (mid_full),
		.empty (mid_empty),
		.count (mid_count)
	);

	assign credit = (SUM_W'(out_count) + SUM_W'(inflight)) < SUM_W'(rgbd_pkg::OUT_DEPTH);
	assign mid_rd = !mid_empty && credit;

	rgbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (mid_rd),
		.in_word  (mid_word),
		.out_valid(back_valid),
		.out_word (back_word),
		.inflight (inflight)
	);

	rgbd_fifo #(
		.WIDTH($bits(rgbd_pkg::point_t)),
		.DEPTH(rgbd_pkg::OUT_DEPTH)
	) u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (back_valid),
		.wdata (back_word),
		.rd    (pop && !out_empty),
		.rdata (point),
		.full  (out_full),
		.empty (out_empty),
		.count (out_count)
	);

	assign empty = out_empty;

	`RGBD_NEVER(a_out_overflow, back_valid && out_full, "result queue written while full")
	`RGBD_NEVER(a_mid_count, mid_count > MID_CW'(rgbd_pkg::MID_DEPTH), "mid queue count past depth")
	`RGBD_HOLDS(a_zero_depth_drop, push && !full && pixel.depth_raw == '0 |=> !kept.valid, "zero depth kept")
	`RGBD_HOLDS(a_odd_row_drop, push && !full && pixel.pixel_row[0] |=> !kept.valid, "odd row kept")
endmodule
